[rtl/core/binary_search_with_probe_count_unit_defines.svh]
// Assertion macros for the binary search unit.
`ifndef BINARY_SEARCH_WITH_PROBE_COUNT_UNIT_DEFINES_SVH
`define BINARY_SEARCH_WITH_PROBE_COUNT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSPC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BSPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bspc_pkg.sv]
package bspc_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;

    localparam int unsigned IDX_W   = 10;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned WIN_W   = IDX_W + 2;
    localparam int unsigned MAX_PROBES = 11;

    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

    // s_tdata: entry_index, entry_value, search_key; padded to bytes
    localparam int unsigned S_DATA_RAW = IDX_W + 2 * VAL_W;
    localparam int unsigned S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;
    // m_tdata: found, match_index, probe_count; padded to bytes
    localparam int unsigned M_DATA_RAW = 1 + IDX_W + CNT_W;
    localparam int unsigned M_DATA_W   = ((M_DATA_RAW + 7) / 8) * 8;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic {
        REG_RANGE_LOW  = 1'b0,
        REG_RANGE_HIGH = 1'b1
    } reg_sel_t;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } opcode_t;

endpackage

[rtl/core/binary_search_with_probe_count_unit.sv]
// Binary search over a table of signed 32-bit words held in a one-port synchronous RAM.
// A load word (tuser 0) writes one entry and gives no result; indices at or beyond
// TABLE_DEPTH are dropped. A search word (tuser 1) probes the midpoint of [range_low,
// range_high] (range_high clamped to TABLE_DEPTH - 1), one probe per cycle, since each
// probe is one RAM read and its compare picks the next address. A search therefore
// holds the input until it finishes, and an empty range answers without a probe. The
// result sits in an output register, so the next word is taken while it waits; a
// finished search whose result cannot yet leave holds in a wait state. The table is
// undefined until written and must be loaded in ascending order for a search to be
// exact. Range registers live at APB addresses 0x0 (range_low) and 0x4 (range_high)
// and should be written only while idle.
`include "binary_search_with_probe_count_unit_defines.svh"

module binary_search_with_probe_count_unit #(
    parameter int unsigned TABLE_DEPTH = bspc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index[9:0], entry_value[41:10], search_key[73:42], zero pad
    input  logic [bspc_pkg::S_DATA_W-1:0]     s_tdata,
    // opcode[0]
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // found[0], match_index[10:1], probe_count[14:11], zero pad
    output logic [bspc_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bspc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bspc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bspc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import bspc_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] HI_CAP =
        (TABLE_DEPTH - 1 > int'(IDX_MAX)) ? IDX_MAX : IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_WAIT
    } state_t;

    state_t                    state_reg;
    logic [IDX_W-1:0]          range_low_reg;
    logic [IDX_W-1:0]          range_high_reg;
    logic signed [WIN_W-1:0]   lo_reg;
    logic signed [WIN_W-1:0]   hi_reg;
    logic [IDX_W-1:0]          mid_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [VAL_W-1:0]   key_reg;
    logic [VAL_W-1:0]          rd_data_reg;
    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic                      out_found_reg;
    logic [IDX_W-1:0]          out_idx_reg;
    logic [CNT_W-1:0]          out_cnt_reg;
    logic                      pend_found_reg;
    logic [IDX_W-1:0]          pend_idx_reg;
    logic [CNT_W-1:0]          pend_cnt_reg;

    logic [VAL_W-1:0]          tbl_mem [TABLE_DEPTH];

    opcode_t                   in_op;
    logic [IDX_W-1:0]          in_idx;
    logic [VAL_W-1:0]          in_val;
    logic [VAL_W-1:0]          in_key;
    logic                      s_acc;
    logic                      start;
    logic                      wr_en;
    logic                      out_free;
    logic                      res_post;
    logic [IDX_W-1:0]          hi_sat;
    logic signed [WIN_W-1:0]   win_lo;
    logic signed [WIN_W-1:0]   win_hi;
    logic signed [WIN_W-1:0]   win_sum;
    logic [IDX_W-1:0]          mid_next;
    logic [CNT_W-1:0]          cnt_base;
    logic                      issue;
    logic                      finish;
    logic                      res_found;
    logic [IDX_W-1:0]          res_idx;
    logic                      cfg_wr;

    assign in_op  = opcode_t'(s_tuser[0]);
    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_val = s_tdata[IDX_W+VAL_W-1:IDX_W];
    assign in_key = s_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign start    = s_acc && (in_op == OP_SEARCH);
    assign wr_en    = s_acc && (in_op == OP_LOAD) && (32'(in_idx) < 32'(TABLE_DEPTH));
    assign out_free = !m_tvalid_reg || m_tready;
    assign hi_sat   = (range_high_reg > HI_CAP) ? HI_CAP : range_high_reg;

    // One probe step: load the window on a start or narrow it on the last read, then issue the next midpoint.
    always_comb begin
        win_lo    = lo_reg;
        win_hi    = hi_reg;
        cnt_base  = cnt_reg;
        res_found = 1'b0;
        res_idx   = '0;
        if (start) begin
            win_lo   = WIN_W'(range_low_reg);
            win_hi   = WIN_W'(hi_sat);
            cnt_base = '0;
        end else if (state_reg == S_PROBE) begin
            priority if ($signed(key_reg) < $signed(rd_data_reg)) begin
                win_hi = WIN_W'(mid_reg) - WIN_W'(1);
            end else if ($signed(key_reg) > $signed(rd_data_reg)) begin
                win_lo = WIN_W'(mid_reg) + WIN_W'(1);
            end else begin
                res_found = 1'b1;
                res_idx   = mid_reg;
            end
        end
        win_sum  = win_lo + win_hi;
        mid_next = win_sum[IDX_W:1];
        issue    = (start || ((state_reg == S_PROBE) && !res_found)) && (win_lo <= win_hi);
        finish   = (start || (state_reg == S_PROBE)) && !issue;
    end

    // a result enters the output register on the same edge the old one may leave
    assign res_post      = out_free && (finish || (state_reg == S_WAIT));
    assign m_tvalid_next = res_post ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[AW'(in_idx)] <= in_val;
        end
        if (issue) begin
            rd_data_reg <= tbl_mem[AW'(mid_next)];
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg <= $signed(in_key);
        end
        if (issue) begin
            lo_reg  <= win_lo;
            hi_reg  <= win_hi;
            mid_reg <= mid_next;
            cnt_reg <= cnt_base + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            unique case (state_reg)
                S_IDLE, S_PROBE: begin
                    if (issue) begin
                        state_reg <= S_PROBE;
                    end else if (finish) begin
                        if (out_free) begin
                            out_found_reg <= res_found;
                            out_idx_reg   <= res_idx;
                            out_cnt_reg   <= cnt_base;
                            state_reg     <= S_IDLE;
                        end else begin
                            pend_found_reg <= res_found;
                            pend_idx_reg   <= res_idx;
                            pend_cnt_reg   <= cnt_base;
                            state_reg      <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (out_free) begin
                        out_found_reg <= pend_found_reg;
                        out_idx_reg   <= pend_idx_reg;
                        out_cnt_reg   <= pend_cnt_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({out_cnt_reg, out_idx_reg, out_found_reg});

    // APB register file
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg  <= '0;
            range_high_reg <= IDX_MAX;
        end else if (cfg_wr) begin
            unique case (reg_sel_t'(paddr[2]))
                REG_RANGE_LOW:  range_low_reg  <= pwdata[IDX_W-1:0];
                REG_RANGE_HIGH: range_high_reg <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel_t'(paddr[2]))
            REG_RANGE_LOW:  prdata = APB_DATA_W'(range_low_reg);
            REG_RANGE_HIGH: prdata = APB_DATA_W'(range_high_reg);
            default:        prdata = '0;
        endcase
    end

    `BSPC_ASSERT_IMPL(a_window_open, aclk, aresetn, state_reg == S_PROBE,
        lo_reg <= hi_reg, "probing an empty window")
    `BSPC_ASSERT_IMPL(a_probe_bound, aclk, aresetn, state_reg == S_PROBE,
        cnt_reg <= CNT_W'(MAX_PROBES), "probe count past bound")
    `BSPC_ASSERT_IMPL(a_miss_index, aclk, aresetn, m_tvalid_reg && !out_found_reg,
        out_idx_reg == '0, "miss with nonzero index")
    `BSPC_ASSERT_IMPL(a_hit_probed, aclk, aresetn, m_tvalid_reg && out_found_reg,
        out_cnt_reg != '0, "hit without a probe")
    `BSPC_ASSERT_NEXT(a_wait_holds, aclk, aresetn,
        (state_reg == S_WAIT) && m_tvalid_reg && !m_tready,
        state_reg == S_WAIT, "pending result lost")

endmodule
